// File: src/itoa_pkg.sv
// itoa_pkg: shared types, format codes and constants for the integer-to-ASCII formatter.
// No dependencies; used by every file in src.
`default_nettype none

package itoa_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned FMT_W    = 2;
	localparam int unsigned CHAR_W   = 8;
	localparam int unsigned COUNT_W  = 4;
	localparam int unsigned DIGIT_W  = 4;
	localparam int unsigned MAX_DIGITS = 10;

	localparam logic [FMT_W-1:0] FMT_SDEC = 2'd0;
	localparam logic [FMT_W-1:0] FMT_UDEC = 2'd1;
	localparam logic [FMT_W-1:0] FMT_HEXL = 2'd2;
	localparam logic [FMT_W-1:0] FMT_HEXU = 2'd3;

	localparam logic [CHAR_W-1:0] ASCII_ZERO   = 8'd48;
	localparam logic [CHAR_W-1:0] ASCII_UPPER  = 8'd55;
	localparam logic [CHAR_W-1:0] ASCII_LOWER  = 8'd87;
	localparam logic [CHAR_W-1:0] ASCII_MINUS  = 8'd45;

	// floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for every 32-bit x
	localparam logic [VALUE_W-1:0] RECIP10     = 32'hCCCC_CCCD;
	localparam int unsigned        RECIP_SHIFT = 35;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic load;
		logic step;
		logic push;
	} cmd_t;

	typedef struct packed {
		logic quot_zero;
		logic out_free;
		logic last_next;
	} sts_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d,
			input logic upper);
		logic [CHAR_W-1:0] dx;
		dx = {{(CHAR_W-DIGIT_W){1'b0}}, d};
		if (d < 4'd10) begin
			return ASCII_ZERO + dx;
		end else if (upper) begin
			return ASCII_UPPER + dx;
		end else begin
			return ASCII_LOWER + dx;
		end
	endfunction

endpackage

`default_nettype wire

// File: src/itoa_if.sv
// itoa_in_if / itoa_out_if: valid-ready channels for the formatter's input and result items.
// Depends on itoa_pkg for field widths.
`default_nettype none

interface itoa_in_if;
	logic                                valid;
	logic                                ready;
	logic [itoa_pkg::VALUE_W-1:0]        value;
	logic [itoa_pkg::FMT_W-1:0]          req_type;

	modport source(output valid, output value, output req_type, input ready);
	modport sink(input valid, input value, input req_type, output ready);
endinterface

interface itoa_out_if;
	logic                                valid;
	logic                                ready;
	logic [itoa_pkg::CHAR_W-1:0]         ascii_char;
	logic                                is_last;
	logic [itoa_pkg::COUNT_W-1:0]        char_count;

	modport source(output valid, output ascii_char, output is_last, output char_count,
		input ready);
	modport sink(input valid, input ascii_char, input is_last, input char_count,
		output ready);
endinterface

`default_nettype wire

// File: src/itoa_ctrl.sv
// itoa_ctrl: sequencing state machine (accept, digit conversion, character emit).
// Depends on itoa_pkg for state, command and status types.
`default_nettype none

module itoa_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_ready,
	input  itoa_pkg::sts_t      sts,
	output itoa_pkg::cmd_t      cmd
);

	itoa_pkg::state_t state_q;
	itoa_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itoa_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				if (in_valid) state_d = itoa_pkg::ST_CONV;
			end
			itoa_pkg::ST_CONV: begin
				if (sts.quot_zero) state_d = itoa_pkg::ST_EMIT;
			end
			itoa_pkg::ST_EMIT: begin
				if (sts.out_free && sts.last_next) state_d = itoa_pkg::ST_IDLE;
			end
			default: begin
				state_d = itoa_pkg::ST_IDLE;
			end
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd      = '0;
		case (state_q)
			itoa_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			itoa_pkg::ST_CONV: begin
				cmd.step = 1'b1;
			end
			itoa_pkg::ST_EMIT: begin
				cmd.push = sts.out_free;
			end
			default: begin
				in_ready = 1'b0;
			end
		endcase
	end

	a_load_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == itoa_pkg::ST_CONV)
		else $error("load did not start conversion");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.step, cmd.push}))
		else $error("more than one datapath command");

	a_last_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && sts.last_next) |=> in_ready)
		else $error("not ready after last character");

endmodule

`default_nettype wire

// File: src/itoa_dp.sv
// itoa_dp: datapath - magnitude register, divide-by-base step, digit buffer, output register.
// Depends on itoa_pkg; commanded by itoa_ctrl.
`default_nettype none

module itoa_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  itoa_pkg::cmd_t                     cmd,
	output itoa_pkg::sts_t                     sts,
	input  wire logic [itoa_pkg::VALUE_W-1:0]  value,
	input  wire logic [itoa_pkg::FMT_W-1:0]    req_type,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [itoa_pkg::CHAR_W-1:0]        ascii_char,
	output logic                               is_last,
	output logic [itoa_pkg::COUNT_W-1:0]       char_count
);

	logic [itoa_pkg::VALUE_W-1:0]   mag_q;
	logic                           hex_q;
	logic                           upper_q;
	logic                           neg_q;
	logic [itoa_pkg::COUNT_W-1:0]   cnt_q;
	logic [itoa_pkg::COUNT_W-1:0]   cc_q;
	logic [itoa_pkg::DIGIT_W-1:0]   rev_q [itoa_pkg::MAX_DIGITS];

	logic                           ov_q;
	logic [itoa_pkg::CHAR_W-1:0]    ch_q;
	logic                           last_q;
	logic [itoa_pkg::COUNT_W-1:0]   ccnt_q;

	logic                           neg_in;
	logic [2*itoa_pkg::VALUE_W-1:0] prod;
	logic [itoa_pkg::VALUE_W-1:0]   quot_dec;
	logic [itoa_pkg::VALUE_W-1:0]   q10;
	logic [itoa_pkg::VALUE_W-1:0]   rem_dec;
	logic [itoa_pkg::VALUE_W-1:0]   quot;
	logic [itoa_pkg::DIGIT_W-1:0]   digit;
	logic [itoa_pkg::COUNT_W-1:0]   rd_idx;
	logic [itoa_pkg::CHAR_W-1:0]    next_ch;

	assign neg_in = (req_type == itoa_pkg::FMT_SDEC) && value[itoa_pkg::VALUE_W-1];

	assign prod     = {{itoa_pkg::VALUE_W{1'b0}}, mag_q} *
		{{itoa_pkg::VALUE_W{1'b0}}, itoa_pkg::RECIP10};
	assign quot_dec = {{(itoa_pkg::RECIP_SHIFT-itoa_pkg::VALUE_W){1'b0}},
		prod[2*itoa_pkg::VALUE_W-1:itoa_pkg::RECIP_SHIFT]};
	assign q10      = (quot_dec << 3) + (quot_dec << 1);
	assign rem_dec  = mag_q - q10;

	always_comb begin
		if (hex_q) begin
			quot  = mag_q >> itoa_pkg::DIGIT_W;
			digit = mag_q[itoa_pkg::DIGIT_W-1:0];
		end else begin
			quot  = quot_dec;
			digit = rem_dec[itoa_pkg::DIGIT_W-1:0];
		end
	end

	assign rd_idx  = cnt_q - 4'd1;
	assign next_ch = neg_q ? itoa_pkg::ASCII_MINUS :
		itoa_pkg::digit_char(rev_q[rd_idx], upper_q);

	assign sts.quot_zero = (quot == '0);
	assign sts.out_free  = !ov_q || out_ready;
	assign sts.last_next = !neg_q && (cnt_q == 4'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			neg_q <= 1'b0;
			cc_q  <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
			neg_q <= neg_in;
			cc_q  <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 4'd1;
		end else if (cmd.push) begin
			cc_q <= cc_q + 4'd1;
			if (neg_q) begin
				neg_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q - 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mag_q   <= neg_in ? (~value + 32'd1) : value;
			hex_q   <= req_type[1];
			upper_q <= (req_type == itoa_pkg::FMT_HEXU);
		end else if (cmd.step) begin
			mag_q         <= quot;
			rev_q[cnt_q]  <= digit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (cmd.push) begin
			ov_q <= 1'b1;
		end else if (out_ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			ch_q   <= next_ch;
			last_q <= sts.last_next;
			ccnt_q <= cc_q + 4'd1;
		end
	end

	assign out_valid  = ov_q;
	assign ascii_char = ch_q;
	assign is_last    = last_q;
	assign char_count = ccnt_q;

	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> cnt_q < 4'(itoa_pkg::MAX_DIGITS))
		else $error("digit buffer overflow");

	a_push_has_char: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> (neg_q || cnt_q != '0))
		else $error("push with no character left");

	a_minus_first: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && neg_q) |-> (cc_q == '0 && !sts.last_next))
		else $error("minus sign not first or marked last");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |-> !cmd.push)
		else $error("output register overwritten while stalled");

endmodule

`default_nettype wire

// File: src/integer_to_ascii_formatter.sv
// integer_to_ascii_formatter: top level, joins itoa_ctrl and itoa_dp to the item channels.
// Depends on itoa_pkg, itoa_if, itoa_ctrl and itoa_dp.
//
// Usage:
//   in_ch carries one item: a 32-bit value and a 2-bit format (signed decimal,
//   unsigned decimal, lowercase hex, uppercase hex). out_ch carries one ASCII
//   character per item, most significant digit first, no leading zeros, with a
//   leading '-' for negative values in signed mode, an is_last flag on the final
//   character and a running char_count (1..11).
//   After an input is accepted the block produces its digits (1..10 for decimal,
//   1..8 for hex) one at a time, dividing the magnitude by the base (a reciprocal
//   multiply for decimal, a shift for hex), then pushes one character per cycle
//   into its output register while the receiver does not stall.
//   in_ch.ready is high only while idle; the next item may be accepted while
//   the last character still waits. A stalled receiver holds the output
//   register and pauses emission. Reset clears the controller and the output
//   valid; no items are pending.
`default_nettype none

module integer_to_ascii_formatter (
	input  wire logic          clk,
	input  wire logic          arst_n,
	itoa_in_if.sink            in_ch,
	itoa_out_if.source         out_ch
);

	itoa_pkg::cmd_t cmd;
	itoa_pkg::sts_t sts;
	logic           in_ready;

	itoa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_ch.valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	itoa_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.value      (in_ch.value),
		.req_type   (in_ch.req_type),
		.out_valid  (out_ch.valid),
		.out_ready  (out_ch.ready),
		.ascii_char (out_ch.ascii_char),
		.is_last    (out_ch.is_last),
		.char_count (out_ch.char_count)
	);

	assign in_ch.ready = in_ready;

endmodule

`default_nettype wire

// File: tb/integer_to_ascii_formatter_tb.sv
// integer_to_ascii_formatter_tb: self-checking bench for the integer-to-ASCII formatter.
// Depends on itoa_pkg, itoa_if and the RTL under src; drives in_ch, checks every char on out_ch.
// Directed corner values, then random numbers in all four formats with random idle on both sides.
`default_nettype none

module integer_to_ascii_formatter_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 30;
	localparam int RANDOM_ITEMS   = 106;

	typedef struct packed {
		logic [itoa_pkg::CHAR_W-1:0]  ch;
		logic                         last;
		logic [itoa_pkg::COUNT_W-1:0] count;
	} glyph_t;

	class char_scoreboard;
		glyph_t pending_chars[$];
		int     errors;
		int     mismatches;
		int     numbers_seen;
		int     chars_checked;
		int     per_format[4];

		function new();
			errors = 0;
			mismatches = 0;
			numbers_seen = 0;
			chars_checked = 0;
			foreach (per_format[i]) per_format[i] = 0;
		endfunction

		function void note_number(logic [itoa_pkg::VALUE_W-1:0] v,
				logic [itoa_pkg::FMT_W-1:0] f);
			logic [itoa_pkg::VALUE_W-1:0] mag;
			logic [itoa_pkg::VALUE_W-1:0] base;
			logic [itoa_pkg::VALUE_W-1:0] d;
			logic [itoa_pkg::CHAR_W-1:0]  text[$];
			logic                         neg;
			glyph_t                       g;
			neg = (f == itoa_pkg::FMT_SDEC) && v[itoa_pkg::VALUE_W-1];
			mag = neg ? (~v + 1'b1) : v;
			base = (f == itoa_pkg::FMT_HEXL || f == itoa_pkg::FMT_HEXU) ? 32'd16 : 32'd10;
			do begin
				d = mag % base;
				if (d < 10)
					text.push_front(itoa_pkg::ASCII_ZERO + d[itoa_pkg::CHAR_W-1:0]);
				else if (f == itoa_pkg::FMT_HEXU)
					text.push_front(itoa_pkg::ASCII_UPPER + d[itoa_pkg::CHAR_W-1:0]);
				else
					text.push_front(itoa_pkg::ASCII_LOWER + d[itoa_pkg::CHAR_W-1:0]);
				mag = mag / base;
			end while (mag != 0);
			if (neg)
				text.push_front(itoa_pkg::ASCII_MINUS);
			foreach (text[i]) begin
				g.ch = text[i];
				g.last = (i == text.size() - 1);
				g.count = itoa_pkg::COUNT_W'(i + 1);
				pending_chars.push_back(g);
			end
			numbers_seen++;
			per_format[f]++;
		endfunction

		function void report(string msg);
			errors++;
			mismatches++;
			if (mismatches <= 10)
				$display("%0t MISMATCH %s", $realtime, msg);
		endfunction

		function void check_char(logic [itoa_pkg::CHAR_W-1:0] ch, logic last,
				logic [itoa_pkg::COUNT_W-1:0] count);
			glyph_t exp_g;
			chars_checked++;
			if (pending_chars.size() == 0) begin
				report($sformatf("unexpected char 0x%02h last=%0b count=%0d", ch, last, count));
				return;
			end
			exp_g = pending_chars.pop_front();
			if (ch !== exp_g.ch)
				report($sformatf("ascii_char exp 0x%02h got 0x%02h", exp_g.ch, ch));
			if (last !== exp_g.last)
				report($sformatf("is_last exp %0b got %0b (char 0x%02h)", exp_g.last, last,
					exp_g.ch));
			if (count !== exp_g.count)
				report($sformatf("char_count exp %0d got %0d (char 0x%02h)", exp_g.count, count,
					exp_g.ch));
		endfunction

		function void flush_leftovers();
			while (pending_chars.size() > 0) begin
				report($sformatf("char 0x%02h count=%0d never arrived",
					pending_chars[0].ch, pending_chars[0].count));
				void'(pending_chars.pop_front());
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic no_idle;
	int   quiet_cycles;

	char_scoreboard sb;

	itoa_in_if  in_ch();
	itoa_out_if out_ch();

	integer_to_ascii_formatter u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	initial begin
		clk = 1'b0;
	end

	always #4 clk = ~clk;

	function automatic int draw_wait();
		return no_idle ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic send_number(logic [itoa_pkg::VALUE_W-1:0] v, logic [itoa_pkg::FMT_W-1:0] f);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.value    <= v;
		in_ch.req_type <= f;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	function automatic logic [itoa_pkg::VALUE_W-1:0] random_value();
		int unsigned pick;
		int unsigned p;
		logic [itoa_pkg::VALUE_W-1:0] pow10;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: begin
				return itoa_pkg::VALUE_W'($urandom_range(0, 20));
			end
			2: begin
				return 32'h1 << $urandom_range(0, 31);
			end
			3: begin
				pow10 = 1;
				p = $urandom_range(0, 9);
				repeat (p) pow10 = pow10 * 10;
				return pow10 + itoa_pkg::VALUE_W'($urandom_range(0, 2)) - 32'd1;
			end
			4: begin
				return 32'h8000_0000 + itoa_pkg::VALUE_W'($urandom_range(0, 3));
			end
			5: begin
				return 32'hFFFF_FFFF - itoa_pkg::VALUE_W'($urandom_range(0, 20));
			end
			default: begin
				return $urandom();
			end
		endcase
	endfunction

	// stimulus and end of run
	initial begin
		logic [itoa_pkg::VALUE_W-1:0] dir_values[$];
		logic [itoa_pkg::FMT_W-1:0]   dir_formats[$];
		sb = new();
		arst_n = 1'b0;
		no_idle = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.value = '0;
		in_ch.req_type = itoa_pkg::FMT_SDEC;

		dir_values  = '{32'h0, 32'h0, 32'h0, 32'h0,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'h7FFF_FFFF, 32'd1, 32'd9, 32'd10, 32'hDEAD_BEEF, 32'hDEAD_BEEF,
			32'hABCD_EF01, 32'd1000000000, 32'd999999999, 32'h0000_000F,
			32'h0000_0010, 32'h1000_0000, 32'hFFFF_FFF6};
		dir_formats = '{itoa_pkg::FMT_SDEC, itoa_pkg::FMT_UDEC, itoa_pkg::FMT_HEXL,
			itoa_pkg::FMT_HEXU,
			itoa_pkg::FMT_SDEC, itoa_pkg::FMT_UDEC, itoa_pkg::FMT_HEXU,
			itoa_pkg::FMT_SDEC, itoa_pkg::FMT_UDEC, itoa_pkg::FMT_HEXL, itoa_pkg::FMT_HEXU,
			itoa_pkg::FMT_SDEC, itoa_pkg::FMT_SDEC, itoa_pkg::FMT_UDEC, itoa_pkg::FMT_SDEC,
			itoa_pkg::FMT_HEXL, itoa_pkg::FMT_HEXU,
			itoa_pkg::FMT_HEXL, itoa_pkg::FMT_UDEC, itoa_pkg::FMT_SDEC, itoa_pkg::FMT_HEXL,
			itoa_pkg::FMT_HEXU, itoa_pkg::FMT_HEXL, itoa_pkg::FMT_SDEC};

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_values[i])
			send_number(dir_values[i], dir_formats[i]);

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			if (i % 32 == 0)
				no_idle <= ((i / 32) % 2 == 1);
			send_number(random_value(), itoa_pkg::FMT_W'($urandom_range(0, 3)));
		end
		in_ch.valid <= 1'b0;
		no_idle <= 1'b0;
		@(posedge clk);

		while (sb.pending_chars.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.flush_leftovers();

		$display("Converted %0d numbers into %0d checked chars", sb.numbers_seen,
			sb.chars_checked);
		$display("  signed dec %0d, unsigned dec %0d, hex lower %0d, hex upper %0d",
			sb.per_format[itoa_pkg::FMT_SDEC], sb.per_format[itoa_pkg::FMT_UDEC],
			sb.per_format[itoa_pkg::FMT_HEXL], sb.per_format[itoa_pkg::FMT_HEXU]);
		if (sb.errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// result side backpressure
	initial begin
		int stall;
		out_ch.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ch.ready <= 1'b1;
			do @(posedge clk); while (!out_ch.valid);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				sb.note_number(in_ch.value, in_ch.req_type);
			if (out_ch.valid && out_ch.ready)
				sb.check_char(out_ch.ascii_char, out_ch.is_last, out_ch.char_count);
		end
	end

	initial begin
		quiet_cycles = 0;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", quiet_cycles);
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

endmodule

`default_nettype wire
